### hdl/lis_pkg.sv
// Shared types, codes and helpers for the integer literal scanner.
// No dependencies; every other file in hdl imports this package.

package lis_pkg;

	// Width of the accumulator; results wider than this report overflow.
	localparam int VALUE_WIDTH = 64;
	localparam int OUT_WIDTH   = 64;
	localparam int WIDE_WIDTH  = VALUE_WIDTH + 4;

	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_LOWER_X    = 8'h78;
	localparam logic [7:0] CH_UPPER_X    = 8'h58;
	localparam logic [7:0] CH_LOWER_B    = 8'h62;
	localparam logic [7:0] CH_UPPER_B    = 8'h42;

	// Digit value used to mark a byte that is no digit of any base.
	localparam logic [4:0] NOT_DIGIT = 5'd16;

	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_OCT = 2'd1,
		RADIX_HEX = 2'd2,
		RADIX_BIN = 2'd3
	} radix_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_PREFIX   = 2'd1,
		STATUS_DIGIT    = 2'd2,
		STATUS_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       begin_req;
	} byte_beat_t;

	typedef struct packed {
		logic [OUT_WIDTH-1:0] value;
		radix_t               radix;
		status_t              status;
	} lit_beat_t;

	// Outcome of folding one digit into the accumulator.
	typedef struct packed {
		logic [VALUE_WIDTH-1:0] acc_next;
		logic                   overflow;
		logic                   bad_digit;
	} step_t;

	function automatic logic [4:0] digit_of(input logic [7:0] c);
		logic [4:0] d;
		d = NOT_DIGIT;
		if (c inside {[8'h30:8'h39]}) begin
			d = 5'(c - 8'h30);
		end else if (c inside {[8'h61:8'h66]}) begin
			d = 5'(c - 8'h61 + 8'd10);
		end else if (c inside {[8'h41:8'h46]}) begin
			d = 5'(c - 8'h41 + 8'd10);
		end
		return d;
	endfunction

endpackage

### hdl/lis_acc_step.sv
// Multiply-accumulate of one digit in the current base, with exact overflow
// and digit range checks. Depends on lis_pkg.

module lis_acc_step (
	input  logic [lis_pkg::VALUE_WIDTH-1:0] acc,
	input  lis_pkg::radix_t                 radix,
	input  logic [4:0]                      digit,
	output lis_pkg::step_t                  step
);
	import lis_pkg::*;

	logic [WIDE_WIDTH-1:0] wide_acc;
	logic [WIDE_WIDTH-1:0] scaled;
	logic [WIDE_WIDTH-1:0] sum;
	logic [4:0]            base;

	assign wide_acc = WIDE_WIDTH'(acc);

	// Every base is a shift, or for decimal the sum of two shifts.
	always_comb begin
		case (radix)
			RADIX_DEC: begin
				scaled = (wide_acc << 3) + (wide_acc << 1);
				base   = 5'd10;
			end
			RADIX_OCT: begin
				scaled = wide_acc << 3;
				base   = 5'd8;
			end
			RADIX_HEX: begin
				scaled = wide_acc << 4;
				base   = 5'd16;
			end
			RADIX_BIN: begin
				scaled = wide_acc << 1;
				base   = 5'd2;
			end
			default: begin
				scaled = wide_acc;
				base   = 5'd10;
			end
		endcase
	end

	assign sum            = scaled + WIDE_WIDTH'(digit);
	assign step.acc_next  = sum[VALUE_WIDTH-1:0];
	assign step.overflow  = |sum[WIDE_WIDTH-1:VALUE_WIDTH];
	assign step.bad_digit = digit >= base;

endmodule

### hdl/lis_scan_core.sv
// Literal scanning state: phase, base, accumulator and first error, updated
// once per byte. Depends on lis_pkg and lis_acc_step.

module lis_scan_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  lis_pkg::byte_beat_t beat,
	output logic                emit,
	output lis_pkg::lit_beat_t  result
);
	import lis_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_ZERO   = 2'd1,
		PH_DIGITS = 2'd2
	} phase_t;

	phase_t                 phase_q, phase_d;
	radix_t                 radix_q, radix_d;
	status_t                err_q, err_d;
	logic [VALUE_WIDTH-1:0] acc_q, acc_d;
	logic [4:0]             digit;
	logic                   take;
	radix_t                 emit_radix;
	step_t                  step;

	assign digit = digit_of(beat.ch);

	lis_acc_step u_step (
		.acc   (acc_q),
		.radix (radix_q),
		.digit (digit),
		.step  (step)
	);

	always_comb begin
		phase_d    = phase_q;
		radix_d    = radix_q;
		err_d      = err_q;
		acc_d      = acc_q;
		take       = 1'b0;
		emit       = 1'b0;
		emit_radix = radix_q;
		if (beat.begin_req) begin
			acc_d = '0;
			err_d = STATUS_OK;
			if (digit >= 5'd10) begin
				phase_d = PH_IDLE;
				radix_d = RADIX_DEC;
			end else if (digit == 5'd0) begin
				phase_d = PH_ZERO;
				radix_d = RADIX_OCT;
			end else begin
				phase_d = PH_DIGITS;
				radix_d = RADIX_DEC;
				acc_d   = VALUE_WIDTH'(digit);
			end
		end else begin
			case (phase_q)
				PH_ZERO: begin
					phase_d = PH_DIGITS;
					if (beat.ch == CH_LOWER_X || beat.ch == CH_UPPER_X) begin
						radix_d = RADIX_HEX;
					end else if (beat.ch == CH_LOWER_B || beat.ch == CH_UPPER_B) begin
						radix_d = RADIX_BIN;
					end else if (digit < 5'd10) begin
						take = 1'b1;
					end else if (digit < NOT_DIGIT || beat.ch == CH_UNDERSCORE) begin
						err_d = STATUS_PREFIX;
					end else begin
						// A lone zero ends here and reads as decimal.
						radix_d    = RADIX_DEC;
						emit_radix = RADIX_DEC;
						emit       = 1'b1;
						phase_d    = PH_IDLE;
					end
				end
				PH_DIGITS: begin
					if (beat.ch == CH_UNDERSCORE) begin
						phase_d = PH_DIGITS;
					end else if (digit < NOT_DIGIT) begin
						take = 1'b1;
					end else begin
						emit    = 1'b1;
						phase_d = PH_IDLE;
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end

		// Once an error is recorded, later digits are consumed but change nothing.
		if (take && err_q == STATUS_OK) begin
			if (step.bad_digit) begin
				err_d = STATUS_DIGIT;
			end else if (step.overflow) begin
				err_d = STATUS_OVERFLOW;
			end else begin
				acc_d = step.acc_next;
			end
		end
	end

	assign result.value  = (err_q == STATUS_OK) ? OUT_WIDTH'(acc_q) : '0;
	assign result.radix  = emit_radix;
	assign result.status = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			radix_q <= RADIX_DEC;
			err_q   <= STATUS_OK;
			acc_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			radix_q <= radix_d;
			err_q   <= err_d;
			acc_q   <= acc_d;
		end
	end

endmodule

### hdl/integer_literal_scanner.sv
// Top level of the integer literal scanner: input register, scanning core
// and result register. Depends on lis_pkg and lis_scan_core.

// Takes one ASCII byte per clock cycle and returns one beat per finished
// literal (value, base and status). A byte is held in the input register while
// the scanning core folds it into the accumulator with shifts and an add, and
// the literal's result is captured in the result register when that byte is
// consumed. Throughput is one byte per cycle; the input stalls only when a
// byte that ends a literal meets a result register still held by lit_stall.
// There is no reset sequence beyond the asynchronous reset itself.

module integer_literal_scanner (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  lis_pkg::byte_beat_t byte_beat,
	output logic                lit_valid,
	input  logic                lit_stall,
	output lis_pkg::lit_beat_t  lit_beat
);
	import lis_pkg::*;

	logic       valid_s1;
	byte_beat_t beat_s1;
	logic       emit;
	logic       advance;
	logic       fire;
	lit_beat_t  result;
	logic       out_valid_q;
	lit_beat_t  out_beat_q;

	lis_scan_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.beat   (beat_s1),
		.emit   (emit),
		.result (result)
	);

	// A byte that produces no result never waits for the output side.
	assign advance    = !emit || !out_valid_q || !lit_stall;
	assign fire       = valid_s1 && advance;
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall) begin
			beat_s1 <= byte_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (!lit_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			out_beat_q <= result;
		end
	end

	assign lit_valid = out_valid_q;
	assign lit_beat  = out_beat_q;

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for integer_literal_scanner: drives byte beats with
// random gaps and output stalls, and checks every literal beat against its own
// scanner model. Depends on lis_pkg and the RTL under hdl.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lis_pkg::*;

	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_CYCLES = 8;

	localparam logic [7:0] CH_DIGIT0  = 8'h30;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	localparam logic [63:0] VALUE_MAX = {64{1'b1}} >> (64 - VALUE_WIDTH);

	typedef enum logic [1:0] {
		SCAN_IDLE,
		SCAN_ZERO,
		SCAN_DIGITS
	} scan_phase_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_stall;
	byte_beat_t byte_beat = '0;
	logic       lit_valid;
	logic       lit_stall = 1'b0;
	lit_beat_t  lit_beat;

	// Scanner model state.
	scan_phase_t scan_phase = SCAN_IDLE;
	radix_t      scan_radix = RADIX_DEC;
	logic [63:0] scan_acc = '0;
	status_t     scan_err = STATUS_OK;
	lit_beat_t   pending_literals[$];

	int unsigned mismatches = 0;
	int unsigned bytes_sent = 0;
	int unsigned quiet_cycles = 0;
	int unsigned burst_left = 0;
	bit          gaps_on = 1'b1;
	bit          hold_request = 1'b0;
	int unsigned hold_count = 0;
	int unsigned stall_pct = 0;
	int unsigned stall_age = 0;

	integer_literal_scanner DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_beat  (byte_beat),
		.lit_valid  (lit_valid),
		.lit_stall  (lit_stall),
		.lit_beat   (lit_beat)
	);

	always #2 clk = ~clk;

	function automatic logic [4:0] char_digit(logic [7:0] c);
		if (c >= CH_DIGIT0 && c <= CH_DIGIT0 + 8'd9) return 5'(c - CH_DIGIT0);
		if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5) return 5'(c - CH_LOWER_A + 8'd10);
		if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5) return 5'(c - CH_UPPER_A + 8'd10);
		return NOT_DIGIT;
	endfunction

	function automatic logic [7:0] digit_char(int unsigned v);
		if (v < 10) return 8'(CH_DIGIT0 + v);
		return 8'((($urandom_range(1) != 0) ? CH_LOWER_A : CH_UPPER_A) + v - 10);
	endfunction

	// A byte that closes a literal; after a lone zero it must not start a prefix.
	function automatic logic [7:0] end_byte(bit after_zero);
		logic [7:0] c;
		do
			c = 8'($urandom_range(255));
		while (char_digit(c) != NOT_DIGIT || c == CH_UNDERSCORE ||
			(after_zero && (c == CH_LOWER_X || c == CH_UPPER_X)));
		return c;
	endfunction

	task automatic fold_digit(logic [4:0] d);
		logic [63:0] base_n;
		if (scan_err != STATUS_OK) return;
		case (scan_radix)
			RADIX_OCT: base_n = 64'd8;
			RADIX_HEX: base_n = 64'd16;
			RADIX_BIN: base_n = 64'd2;
			default:   base_n = 64'd10;
		endcase
		if (64'(d) >= base_n) begin
			scan_err = STATUS_DIGIT;
		end else if (scan_acc > (VALUE_MAX - 64'(d)) / base_n) begin
			scan_err = STATUS_OVERFLOW;
		end else begin
			scan_acc = scan_acc * base_n + 64'(d);
		end
	endtask

	task automatic close_literal();
		pending_literals.push_back('{
			value:  (scan_err == STATUS_OK) ? OUT_WIDTH'(scan_acc) : '0,
			radix:  scan_radix,
			status: scan_err
		});
		scan_phase = SCAN_IDLE;
	endtask

	task automatic scan_byte(logic [7:0] c, logic start);
		logic [4:0] d;
		d = char_digit(c);
		if (start) begin
			scan_acc = '0;
			scan_err = STATUS_OK;
			if (d >= 10) begin
				scan_phase = SCAN_IDLE;
				scan_radix = RADIX_DEC;
			end else if (d == 0) begin
				scan_phase = SCAN_ZERO;
				scan_radix = RADIX_OCT;
			end else begin
				scan_phase = SCAN_DIGITS;
				scan_radix = RADIX_DEC;
				scan_acc = 64'(d);
			end
		end else if (scan_phase == SCAN_ZERO) begin
			if (c == CH_LOWER_X || c == CH_UPPER_X) begin
				scan_radix = RADIX_HEX;
				scan_phase = SCAN_DIGITS;
			end else if (c == CH_LOWER_B || c == CH_UPPER_B) begin
				scan_radix = RADIX_BIN;
				scan_phase = SCAN_DIGITS;
			end else begin
				scan_phase = SCAN_DIGITS;
				if (d < 10) begin
					fold_digit(d);
				end else if (d < 16 || c == CH_UNDERSCORE) begin
					scan_err = STATUS_PREFIX;
				end else begin
					// A zero on its own is a decimal literal.
					scan_radix = RADIX_DEC;
					close_literal();
				end
			end
		end else if (scan_phase == SCAN_DIGITS && c != CH_UNDERSCORE) begin
			if (d < 16) fold_digit(d);
			else close_literal();
		end
	endtask

	// Offers one byte beat and returns at the edge where it is taken.
	task automatic send_byte(logic [7:0] c, logic start);
		if (gaps_on) begin
			if (burst_left == 0) begin
				byte_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
		end
		byte_valid <= 1'b1;
		byte_beat <= '{ch: c, begin_req: start};
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		scan_byte(c, start);
		bytes_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], i == 0);
	endtask

	task automatic wait_for_results();
		byte_valid <= 1'b0;
		while (pending_literals.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_random_literal();
		int unsigned kind, ndig, v, max_dig, base_n;
		radix_t      rx;
		string       text;
		bit          first_oct;
		kind = $urandom_range(99);
		if (kind < 6) begin
			// Stray bytes while idle, then a begin on a byte that is no digit.
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)), 1'b0);
			send_byte(end_byte(1'b0), 1'b1);
			return;
		end
		if (kind < 11) begin
			// An open literal that the next begin throws away.
			send_byte(8'(CH_DIGIT0 + $urandom_range(1, 9)), 1'b1);
			repeat ($urandom_range(3)) send_byte(digit_char($urandom_range(9)), 1'b0);
			if ($urandom_range(3) == 0) begin
				send_byte(end_byte(1'b0), 1'b1);
				return;
			end
		end
		if (kind >= 11 && kind < 16) begin
			send_byte(CH_DIGIT0, 1'b1);
			send_byte(end_byte(1'b1), 1'b0);
			return;
		end
		if (kind >= 16 && kind < 22) begin
			// Values around the top of the range, just fitting or just overflowing.
			if ($urandom_range(1) != 0) begin
				text = "18446744073709551615";
				text.putc(19, 8'(CH_DIGIT0 + $urandom_range(9)));
				send_text(text);
			end else begin
				send_byte(CH_DIGIT0, 1'b1);
				send_byte(($urandom_range(1) != 0) ? CH_LOWER_X : CH_UPPER_X, 1'b0);
				repeat (16 + $urandom_range(1))
					send_byte(digit_char(($urandom_range(9) == 0) ? 14 : 15), 1'b0);
			end
			send_byte(end_byte(1'b0), 1'b0);
			return;
		end
		if (kind >= 22 && kind < 28) begin
			send_byte(CH_DIGIT0, 1'b1);
			v = $urandom_range(5);
			send_byte((v == 5) ? CH_UNDERSCORE : digit_char((v == 0) ? 10 : v + 11), 1'b0);
			rx = RADIX_OCT;
			ndig = $urandom_range(4);
		end else begin
			case ($urandom_range(3))
				0:       rx = RADIX_DEC;
				1:       rx = RADIX_OCT;
				2:       rx = RADIX_HEX;
				default: rx = RADIX_BIN;
			endcase
			case (rx)
				RADIX_DEC: max_dig = 20;
				RADIX_OCT: max_dig = 22;
				RADIX_HEX: max_dig = 16;
				default:   max_dig = 64;
			endcase
			if ($urandom_range(7) == 0) ndig = max_dig - 1 + $urandom_range(2);
			else ndig = $urandom_range(1, 6);
			if ((rx == RADIX_HEX || rx == RADIX_BIN) && $urandom_range(9) == 0) ndig = 0;
			if (rx == RADIX_DEC) begin
				send_byte(digit_char($urandom_range(1, 9)), 1'b1);
				ndig--;
			end else begin
				send_byte(CH_DIGIT0, 1'b1);
				if (rx == RADIX_HEX)
					send_byte(($urandom_range(1) != 0) ? CH_LOWER_X : CH_UPPER_X, 1'b0);
				else if (rx == RADIX_BIN)
					send_byte(($urandom_range(1) != 0) ? CH_LOWER_B : CH_UPPER_B, 1'b0);
			end
		end
		case (rx)
			RADIX_OCT: base_n = 8;
			RADIX_HEX: base_n = 16;
			RADIX_BIN: base_n = 2;
			default:   base_n = 10;
		endcase
		for (int i = 0; i < ndig; i++) begin
			// The byte right after a leading zero decides the base, so keep it a digit.
			first_oct = (rx == RADIX_OCT && i == 0 && kind >= 28);
			if (!first_oct && $urandom_range(9) == 0) send_byte(CH_UNDERSCORE, 1'b0);
			v = ($urandom_range(19) == 0) ? $urandom_range(15) : $urandom_range(base_n - 1);
			if (first_oct && v > 9) v = 9;
			send_byte(digit_char(v), 1'b0);
		end
		send_byte(end_byte(1'b0), 1'b0);
	endtask

	task automatic test_special_cases();
		send_text("0 ");
		send_text("0x;");
		send_text("0b1_1,");
		send_text("0_ ");
		send_text("0e ");
		send_text("0B2 ");
		send_text("08 ");
		send_text("77");
		send_text("5");
		send_byte(8'h00, 1'b0);
		send_byte("q", 1'b1);
		send_byte("5", 1'b0);
		send_text("3");
		send_byte(8'hFF, 1'b0);
	endtask

	task automatic test_random_literals(int unsigned count);
		count += bytes_sent;
		while (bytes_sent < count) begin
			if ($urandom_range(15) == 0) gaps_on = !gaps_on;
			send_random_literal();
		end
	endtask

	// The receiver holds off while short literals keep coming, so the block
	// backs up and stalls its byte input.
	task automatic test_output_hold();
		gaps_on = 1'b0;
		hold_request = 1'b1;
		repeat (60) begin
			send_byte(8'(CH_DIGIT0 + $urandom_range(9)), 1'b1);
			send_byte(CH_SPACE, 1'b0);
		end
		wait_for_results();
		gaps_on = 1'b1;
	endtask

	always @(posedge clk) begin
		if (hold_request && hold_count < HOLD_CYCLES) begin
			lit_stall <= 1'b1;
			hold_count++;
		end else begin
			if (hold_request) begin
				hold_request = 1'b0;
				hold_count = 0;
			end
			if (stall_age == 0) begin
				case ($urandom_range(4))
					0, 1:    stall_pct = 0;
					2:       stall_pct = 25;
					3:       stall_pct = 50;
					default: stall_pct = 90;
				endcase
				stall_age = $urandom_range(16, 96);
			end
			stall_age--;
			lit_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : check_literals
		lit_beat_t want;
		if (arst_n && lit_valid && !lit_stall) begin
			if (pending_literals.size() == 0) begin
				$error("unexpected literal beat: value %h radix %0d status %0d",
					lit_beat.value, lit_beat.radix, lit_beat.status);
				mismatches++;
			end else begin
				want = pending_literals.pop_front();
				if (lit_beat.value !== want.value) begin
					$error("value: expected %h, got %h", want.value, lit_beat.value);
					mismatches++;
				end
				if (lit_beat.radix !== want.radix) begin
					$error("radix: expected %0d, got %0d", want.radix, lit_beat.radix);
					mismatches++;
				end
				if (lit_beat.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, lit_beat.status);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (lit_valid && !lit_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[integer_literal_scanner] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_cases();
		wait_for_results();
		test_random_literals(850);
		test_output_hold();
		test_random_literals(850);
		wait_for_results();
		if (mismatches == 0) begin
			$display("[integer_literal_scanner] OK");
		end else begin
			$display("[integer_literal_scanner] ERROR");
		end
		$finish;
	end

endmodule
